@@ rtl/ahmt_pkg.sv @@
// Shared types, constants and the address hash for the address-hash memory test core.
// No dependencies; imported by address_hash_memory_test_core.
package ahmt_pkg;

  typedef logic [31:0] word_t;
  typedef logic [29:0] waddr_t;   // word address, byte address bits [31:2]
  typedef logic [3:0]  limit_t;

  typedef enum logic [1:0] {
    CmdWrite   = 2'd0,
    CmdCheck   = 2'd1,
    CmdRestart = 2'd2,
    CmdIdle    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RegWindowLow   = 2'd0,
    RegWindowHigh  = 2'd1,
    RegReportLimit = 2'd2,
    RegNone        = 2'd3
  } reg_idx_e;

  localparam word_t  HashMult        = 32'd2654435761;
  localparam int     HashShift       = 15;
  localparam word_t  WordStep        = 32'd4;
  localparam word_t  WindowLowReset  = 32'h0101_0000;
  localparam word_t  WindowHighReset = 32'h0102_0000;
  localparam limit_t ReportLimitReset = 4'd8;
  localparam word_t  CountMax        = 32'hFFFF_FFFF;

  // Multiplicative hash, product kept modulo 2^32, then fold the high bits down.
  function automatic word_t hash_pattern(input word_t addr);
    word_t h;
    h = word_t'(addr * HashMult);
    return h ^ (h >> HashShift);
  endfunction

endpackage

@@ rtl/address_hash_memory_test_core.sv @@
// Address-hash memory test core: address walk, hashed pattern, mismatch counting.
// Depends on ahmt_pkg (types, command codes, hash function).
//
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_stall_o   command_i, read_data_i
// out      output     out_valid_o / out_stall_i access_valid_o .. pass_last_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One word per cycle while out_stall_i is low; an accepted word passes the input register,
// then hash, compare and counters into the result register, before it reaches the output.
// Reset clears the window to its default, the walk address to the window low bound and
// both counters. A stalled output holds the result register; one more word is taken into
// a skid register, after which in_stall_o rises until the pipeline moves again.
module address_hash_memory_test_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  ahmt_pkg::word_t       read_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  access_valid_o,
  output ahmt_pkg::word_t       address_o,
  output ahmt_pkg::word_t       pattern_o,
  output logic                  mismatch_o,
  output logic                  report_o,
  output ahmt_pkg::word_t       error_count_o,
  output logic                  pass_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  ahmt_pkg::word_t       cfg_data_i
);
  import ahmt_pkg::*;

  // configuration
  waddr_t win_lo_q, win_hi_q;
  limit_t limit_q;

  // state
  waddr_t cur_q, cur_d;
  word_t  err_q, err_d;
  limit_t rep_cnt_q, rep_cnt_d;

  // input register and skid
  logic  s1_v_q, skid_v_q;
  cmd_e  s1_cmd_q, skid_cmd_q;
  word_t s1_rd_q, skid_rd_q;

  // result register
  logic  out_v_q;
  logic  acc_q, mis_q, rep_q, last_q;
  word_t addr_q, pat_q;

  logic  accept, adv, s1_load, fire;
  word_t lo, hi, cur, addr_sel, addr_nxt, pat;
  logic  non_empty, step, mis, rep, last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_v_q;
  assign accept      = in_valid_i && !skid_v_q;
  assign adv         = !out_v_q || !out_stall_i;
  assign s1_load     = adv || !s1_v_q;
  assign fire        = adv && s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= WindowLowReset[31:2];
      win_hi_q <= WindowHighReset[31:2];
      limit_q  <= ReportLimitReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegWindowLow:   win_lo_q <= cfg_data_i[31:2];
        RegWindowHigh:  win_hi_q <= cfg_data_i[31:2];
        RegReportLimit: limit_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input side: take into s1 when it moves, else park one word in the skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (s1_load) begin
      s1_v_q   <= skid_v_q || accept;
      skid_v_q <= 1'b0;
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cmd_q <= skid_v_q ? skid_cmd_q : cmd_e'(command_i);
      s1_rd_q  <= skid_v_q ? skid_rd_q : read_data_i;
    end else if (accept) begin
      skid_cmd_q <= cmd_e'(command_i);
      skid_rd_q  <= read_data_i;
    end
  end

  // Address walk, hash and mismatch accounting for the word in s1.
  always_comb begin
    lo        = {win_lo_q, 2'b00};
    hi        = {win_hi_q, 2'b00};
    cur       = {cur_q, 2'b00};
    non_empty = lo < hi;
    step      = non_empty && (s1_cmd_q == CmdWrite || s1_cmd_q == CmdCheck);
    addr_sel  = (cur < lo || cur >= hi) ? lo : cur;
    addr_nxt  = addr_sel + WordStep;  // addr_sel < hi in a non-empty window, cannot wrap
    pat       = hash_pattern(addr_sel);
    last      = step && (addr_nxt >= hi);
    mis       = step && (s1_cmd_q == CmdCheck) && (s1_rd_q != pat);
    rep       = mis && (rep_cnt_q < limit_q);

    cur_d     = cur_q;
    err_d     = err_q;
    rep_cnt_d = rep_cnt_q;
    if (s1_cmd_q == CmdRestart) begin
      cur_d     = win_lo_q;
      err_d     = '0;
      rep_cnt_d = '0;
    end else if (step) begin
      cur_d = last ? win_lo_q : addr_nxt[31:2];
      if (mis && err_q != CountMax) err_d = err_q + 32'd1;
      if (rep) rep_cnt_d = rep_cnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= WindowLowReset[31:2];
      err_q     <= '0;
      rep_cnt_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (adv) out_v_q <= s1_v_q;
      if (fire) begin
        cur_q     <= cur_d;
        err_q     <= err_d;
        rep_cnt_q <= rep_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q  <= step;
      addr_q <= step ? addr_sel : '0;
      pat_q  <= step ? pat : '0;
      mis_q  <= mis;
      rep_q  <= rep;
      last_q <= last;
    end
  end

  assign out_valid_o    = out_v_q;
  assign access_valid_o = acc_q;
  assign address_o      = addr_q;
  assign pattern_o      = pat_q;
  assign mismatch_o     = mis_q;
  assign report_o       = rep_q;
  assign error_count_o  = err_q;
  assign pass_last_o    = last_q;

  // The skid register only holds a word while s1 is occupied.
  a_skid_behind_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> s1_v_q)
    else $error("skid register full while input register empty");

  // A report is always a mismatch, and a mismatch needs a produced address.
  a_report_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!report_o || mismatch_o) && (!mismatch_o || access_valid_o))
    else $error("report or mismatch without a checked address");

  // Reported count never runs past the limit it was checked against.
  a_report_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && rep |=> rep_cnt_q <= $past(limit_q) && rep_cnt_q != 4'd0)
    else $error("report counter beyond limit");

  // A stalled result holds.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(err_q) && $stable(addr_q))
    else $error("result changed while stalled");

endmodule
